[design/assert_macros.svh]
// Assertion macros shared by the RTL of the zero-sum triplet finder.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication check, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/zstf_pkg.sv]
// Package for the zero-sum triplet finder: sizes, sequencer state type.
// Depends on nothing.
package zstf_pkg;

	localparam int unsigned DefMaxValues   = 64;
	localparam int unsigned DefMaxTriplets = 64;
	localparam int unsigned ValW           = 16;

	// sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_LOAD  = 9'b000000001,
		ST_SRD   = 9'b000000010,
		ST_SCMP  = 9'b000000100,
		ST_SRCH  = 9'b000001000,
		ST_RDX   = 9'b000010000,
		ST_SUM   = 9'b000100000,
		ST_TCHK  = 9'b001000000,
		ST_EMIT  = 9'b010000000,
		ST_WAIT  = 9'b100000000
	} state_t;

endpackage

[design/zstf_buffer.sv]
// Value buffer memory for the zero-sum triplet finder.
// Depends on zstf_pkg. One write port, two registered read ports.
module zstf_buffer import zstf_pkg::*; #(
	parameter int unsigned MaxValues = DefMaxValues,
	localparam int unsigned AW = $clog2(MaxValues)
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic signed [ValW-1:0] wdata,
	input  logic [AW-1:0]          raddr_a,
	input  logic [AW-1:0]          raddr_b,
	output logic signed [ValW-1:0] rdata_a,
	output logic signed [ValW-1:0] rdata_b
);

	logic signed [ValW-1:0] mem_q [MaxValues];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[design/zero_sum_triplet_finder_core.sv]
// Top level of the zero-sum triplet finder.
// Depends on zstf_pkg, zstf_buffer and assert_macros.svh.
//
// Usage: input words (value, last) load the buffer one per cycle while the
// block is in its load phase. The word with last=1 is stored too. The block
// then stalls its input and works alone until the final result word is taken.
// Sort: exchange sort through the buffer's two read ports; each pair (a,b)
// is read in SRD and compared in SCMP, and a swap writes a in SCMP and b in
// SRD. Search: each index triple i<j<k is read through SRCH, RDX and SUM
// and tested in TCHK; a zero-sum triple is then checked against the table
// entries one by one. overflow is the drop flag after the whole search, so
// triplets are kept in the table and played out once the scan ends: after
// the EMIT state, one result word per cycle when the receiver does not stall;
// final_res marks the last one, or the single found=0 word when there are
// none.
// Throughput: one data set at a time, no overlap between sets.
// A stall on the output holds the current word unchanged.
// Reset clears counters, flags and the sequencer; memories are not cleared.
module zero_sum_triplet_finder_core import zstf_pkg::*; #(
	parameter int unsigned MaxValues   = DefMaxValues,
	parameter int unsigned MaxTriplets = DefMaxTriplets
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [ValW-1:0] value,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [ValW-1:0] first,
	output logic signed [ValW-1:0] second,
	output logic signed [ValW-1:0] third,
	output logic                   found,
	output logic                   overflow,
	output logic                   final_res
);

	`include "assert_macros.svh"

	localparam int unsigned AW = $clog2(MaxValues);
	localparam int unsigned CW = $clog2(MaxValues + 1);
	localparam int unsigned TW = $clog2(MaxTriplets + 1);
	localparam int unsigned TA = (MaxTriplets > 1) ? $clog2(MaxTriplets) : 1;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] a_q, b_q, c_q;
	logic [TW-1:0] tcnt_q, tidx_q;
	logic drop_q;
	logic signed [ValW-1:0] x_q, y_q;
	logic signed [ValW+1:0] sum_q;
	logic signed [ValW-1:0] tab_x_q [MaxTriplets];
	logic signed [ValW-1:0] tab_y_q [MaxTriplets];
	logic signed [ValW-1:0] tab_z_q [MaxTriplets];
	logic signed [ValW-1:0] tab_rx_q, tab_ry_q, tab_rz_q;
	logic signed [ValW-1:0] z_q;

	// buffer ports
	logic we;
	logic [AW-1:0] waddr, ra, rb;
	logic signed [ValW-1:0] wdata, rda, rdb;

	zstf_buffer #(.MaxValues(MaxValues)) u_buf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
	);

	logic in_acc, out_acc;
	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	// read address selection: sort reads (a,b); search reads (a,b) then c
	always_comb begin
		ra = a_q[AW-1:0];
		rb = b_q[AW-1:0];
		if (state_q == ST_RDX) begin
			rb = c_q[AW-1:0];
		end
	end

	// registered entry holds table entry tidx-1 during the check
	logic tab_hit;
	assign tab_hit = (tab_rx_q == x_q) && (tab_ry_q == y_q) && (tab_rz_q == z_q);

	// table check decision: skip the triple, or store it as new
	logic sum_nz, tchk_skip, tchk_ins, tab_we;
	always_comb begin
		sum_nz = (sum_q + (ValW+2)'(z_q)) != '0;
		tchk_skip = 1'b0;
		tchk_ins = 1'b0;
		if (state_q == ST_TCHK) begin
			if (tidx_q == '0) begin
				if (sum_nz) begin
					tchk_skip = 1'b1;
				end else if (tcnt_q == '0) begin
					tchk_ins = 1'b1;
				end
			end else if (tab_hit) begin
				tchk_skip = 1'b1;
			end else if (tidx_q == tcnt_q) begin
				tchk_ins = 1'b1;
			end
		end
	end
	assign tab_we = tchk_ins && (tcnt_q < TW'(MaxTriplets));

	// triplet table: one write, one registered read; read ahead on output accept
	logic [TW-1:0] tab_ra_w;
	logic [TA-1:0] tab_ra;
	assign tab_ra_w = (state_q == ST_WAIT && out_acc) ? tidx_q + TW'(1) : tidx_q;
	assign tab_ra   = tab_ra_w[TA-1:0];

	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_x_q[tcnt_q[TA-1:0]] <= x_q;
			tab_y_q[tcnt_q[TA-1:0]] <= y_q;
			tab_z_q[tcnt_q[TA-1:0]] <= z_q;
		end
		tab_rx_q <= tab_x_q[tab_ra];
		tab_ry_q <= tab_y_q[tab_ra];
		tab_rz_q <= tab_z_q[tab_ra];
	end

	// write port: loads and sort swaps
	logic swap_hi;
	always_comb begin
		we = 1'b0;
		waddr = a_q[AW-1:0];
		wdata = value;
		if (in_acc && (cnt_q < CW'(MaxValues))) begin
			we = 1'b1;
			waddr = cnt_q[AW-1:0];
		end else if (state_q == ST_SCMP && rda > rdb) begin
			we = 1'b1;
			waddr = a_q[AW-1:0];
			wdata = rdb;
		end else if (swap_hi) begin
			we = 1'b1;
			waddr = b_q[AW-1:0];
			wdata = x_q;
		end
	end

	logic swap_q;
	assign swap_hi = (state_q == ST_SRD) && swap_q;

	// next triple index step
	logic [CW-1:0] cnt_m1, cnt_m2;
	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			tcnt_q  <= '0;
			tidx_q  <= '0;
			drop_q  <= 1'b0;
			swap_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (cnt_q < CW'(MaxValues)) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (last) begin
							a_q <= '0;
							b_q <= CW'(1);
							swap_q <= 1'b0;
							state_q <= ST_SRD;
						end
					end
				end
				// one compare per pair (a,b); a swap writes the second half next
				ST_SRD: begin
					swap_q <= 1'b0;
					if (swap_q) begin
						b_q <= b_q + CW'(1);
					end else if (b_q >= cnt_q) begin
						if (a_q + CW'(1) >= cnt_q) begin
							a_q <= '0;
							b_q <= CW'(1);
							c_q <= CW'(2);
							tcnt_q <= '0;
							state_q <= ST_SRCH;
						end else begin
							a_q <= a_q + CW'(1);
							b_q <= a_q + CW'(2);
						end
					end else begin
						state_q <= ST_SCMP;
					end
				end
				ST_SCMP: begin
					x_q <= rda;
					if (rda > rdb) begin
						swap_q <= 1'b1;
					end else begin
						b_q <= b_q + CW'(1);
					end
					state_q <= ST_SRD;
				end
				// triple scan control
				ST_SRCH: begin
					if (cnt_q < CW'(3) || a_q >= cnt_m2) begin
						tidx_q <= '0;
						state_q <= ST_EMIT;
					end else if (b_q >= cnt_m1) begin
						a_q <= a_q + CW'(1);
						b_q <= a_q + CW'(2);
						c_q <= a_q + CW'(3);
					end else if (c_q >= cnt_q) begin
						b_q <= b_q + CW'(1);
						c_q <= b_q + CW'(2);
					end else begin
						state_q <= ST_RDX;
					end
				end
				// port b holds value b now; c is read next
				ST_RDX: begin
					y_q <= rdb;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					x_q <= rda;
					sum_q <= (ValW+2)'(rda) + (ValW+2)'(y_q);
					state_q <= ST_TCHK;
					tidx_q <= '0;
				end
				// zero-sum test, then table scan one entry per cycle
				ST_TCHK: begin
					if (tchk_skip) begin
						c_q <= c_q + CW'(1);
						state_q <= ST_SRCH;
					end else if (tchk_ins) begin
						if (tcnt_q < TW'(MaxTriplets)) begin
							tcnt_q <= tcnt_q + TW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						c_q <= c_q + CW'(1);
						state_q <= ST_SRCH;
					end else begin
						tidx_q <= tidx_q + TW'(1);
					end
				end
				ST_EMIT: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_acc) begin
						if (final_res) begin
							cnt_q <= '0;
							drop_q <= 1'b0;
							tcnt_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							tidx_q <= tidx_q + TW'(1);
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// third value register: port b carries c in ST_SUM, after the RDX read
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			z_q <= rdb;
		end
	end

	// output word
	assign out_valid = (state_q == ST_WAIT);
	assign found     = (tcnt_q != '0);
	assign first     = found ? tab_rx_q : '0;
	assign second    = found ? tab_ry_q : '0;
	assign third     = found ? tab_rz_q : '0;
	assign overflow  = drop_q;
	assign final_res = !found || (tidx_q + TW'(1) == tcnt_q);

	`ASSERT_IMPL(a_no_in_busy, clk, arst_n, state_q != ST_LOAD, in_stall)
	`ASSERT_IMPL(a_tab_bound, clk, arst_n, 1'b1, tcnt_q <= TW'(MaxTriplets))
	`ASSERT_NEXT(a_final_back, clk, arst_n, out_acc && final_res,
		state_q == ST_LOAD && cnt_q == '0)

endmodule

[sim/zstf_checker.sv]
// Checker for the zero-sum triplet finder: watches both channels, predicts result words.
// Depends on zstf_pkg for sizes; instantiated beside the block by the testbench top.
module zstf_checker import zstf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic signed [ValW-1:0] value,
	input  logic                   last,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic signed [ValW-1:0] first,
	input  logic signed [ValW-1:0] second,
	input  logic signed [ValW-1:0] third,
	input  logic                   found,
	input  logic                   overflow,
	input  logic                   final_res,
	output int                     errors,
	output int                     pending,
	output int                     words_seen,
	output int                     runs_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [ValW-1:0] lo;
		logic signed [ValW-1:0] mid;
		logic signed [ValW-1:0] hi;
		logic                   fnd;
		logic                   ovf;
		logic                   fin;
	} triplet_word_t;

	triplet_word_t expected_words[$];

	int  vals [DefMaxValues];
	int  nvals;
	logic dropped;
	int  trip [DefMaxTriplets][3];
	int  ntrip;

	// sort the loaded set, scan all triples, queue the expected words
	task automatic find_triplets();
		int a, b, c, t, tmp;
		bit dup;
		triplet_word_t w;
		for (a = 0; a < nvals; a++)
			for (b = a + 1; b < nvals; b++)
				if (vals[a] > vals[b]) begin
					tmp = vals[a];
					vals[a] = vals[b];
					vals[b] = tmp;
				end
		ntrip = 0;
		for (a = 0; a + 2 < nvals; a++)
			for (b = a + 1; b + 1 < nvals; b++)
				for (c = b + 1; c < nvals; c++) begin
					if (vals[a] + vals[b] + vals[c] != 0) continue;
					dup = 0;
					for (t = 0; t < ntrip; t++)
						if (trip[t][0] == vals[a] && trip[t][1] == vals[b] &&
						    trip[t][2] == vals[c])
							dup = 1;
					if (dup) continue;
					if (ntrip >= DefMaxTriplets) begin
						dropped = 1;
						continue;
					end
					trip[ntrip][0] = vals[a];
					trip[ntrip][1] = vals[b];
					trip[ntrip][2] = vals[c];
					ntrip++;
				end
		if (ntrip == 0) begin
			w = '0;
			w.ovf = dropped;
			w.fin = 1;
			expected_words.push_back(w);
		end else begin
			for (t = 0; t < ntrip; t++) begin
				w.lo  = ValW'(trip[t][0]);
				w.mid = ValW'(trip[t][1]);
				w.hi  = ValW'(trip[t][2]);
				w.fnd = 1;
				w.ovf = dropped;
				w.fin = (t + 1 == ntrip);
				expected_words.push_back(w);
			end
		end
	endtask

	// input side: load model buffer, predict on the last word
	always @(posedge clk) begin
		if (!arst_n) begin
			nvals   <= 0;
			dropped <= 0;
		end else if (in_valid && !in_stall) begin
			if (nvals < DefMaxValues) begin
				vals[nvals] = int'(value);
				nvals = nvals + 1;
			end else begin
				dropped = 1;
			end
			if (last) begin
				find_triplets();
				pending = expected_words.size();
				nvals = 0;
				dropped = 0;
				runs_seen++;
			end
		end
	end

	// output side: compare each accepted word against the oldest expectation
	always @(posedge clk) begin
		triplet_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %0d %0d %0d found=%0b ovf=%0b fin=%0b",
					$time, first, second, third, found, overflow, final_res);
				errors++;
			end else begin
				e = expected_words.pop_front();
				pending = expected_words.size();
				if (first !== e.lo) begin
					$display("%0t: first expected %0d actual %0d", $time, e.lo, first);
					errors++;
				end
				if (second !== e.mid) begin
					$display("%0t: second expected %0d actual %0d", $time, e.mid, second);
					errors++;
				end
				if (third !== e.hi) begin
					$display("%0t: third expected %0d actual %0d", $time, e.hi, third);
					errors++;
				end
				if (found !== e.fnd) begin
					$display("%0t: found expected %0b actual %0b", $time, e.fnd, found);
					errors++;
				end
				if (overflow !== e.ovf) begin
					$display("%0t: overflow expected %0b actual %0b", $time, e.ovf, overflow);
					errors++;
				end
				if (final_res !== e.fin) begin
					$display("%0t: final_res expected %0b actual %0b", $time, e.fin,
						final_res);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		pending = 0;
		words_seen = 0;
		runs_seen = 0;
	end
endmodule

[sim/zero_sum_triplet_finder_core_tb.sv]
// Testbench top for the zero-sum triplet finder: drives data sets, random stalls, verdict.
// Depends on zstf_pkg, zero_sum_triplet_finder_core and zstf_checker.
module zero_sum_triplet_finder_core_tb;
	import zstf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic signed [ValW-1:0] value;
	logic                   last;
	logic                   out_valid;
	logic                   out_stall;
	logic signed [ValW-1:0] first, second, third;
	logic                   found, overflow, final_res;
	int                     errors, pending, words_seen, runs_seen;
	bit                     calm;
	int                     random_words;

	zero_sum_triplet_finder_core uut (.*);

	zstf_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// receiver stalls at random outside the calm stretch
	always @(posedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);

	// send one word, with random idle cycles ahead of it
	task automatic send_word(input logic signed [ValW-1:0] v, input logic l);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		value    <= v;
		last     <= l;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_set(input int vs[$]);
		int i;
		for (i = 0; i < vs.size(); i++)
			send_word(ValW'(vs[i]), i == vs.size() - 1);
	endtask

	// mostly small values so zero sums are common, sometimes full range
	function automatic int pick_value();
		if ($urandom_range(99) < 80)
			return $urandom_range(12) - 6;
		return $signed(16'($urandom));
	endfunction

	initial begin
		int vs[$];
		int perm[64];
		int i, j, tmp, n, run;
		in_valid  = 0;
		value     = 0;
		last      = 0;
		out_stall = 0;
		calm      = 0;
		arst_n    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: short sets, extremes, duplicates
		send_set('{32767});
		send_set('{-32768, 0});
		send_set('{-32768, 32767, 1});
		send_set('{0, 0, 0, 0});
		send_set('{-1, 0, 1, 2, -1, -4});
		send_set('{1, 2, 3});
		send_set('{-5, 2, 3, -5, 3, 2});

		// full buffer of distinct values: more triplets than the table holds
		for (i = 0; i < 64; i++) perm[i] = i - 32;
		for (i = 63; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
		end
		vs = {};
		for (i = 0; i < 64; i++) vs.push_back(perm[i]);
		send_set(vs);

		// more values than the buffer holds
		vs = {};
		for (i = 0; i < 70; i++) vs.push_back(pick_value());
		send_set(vs);

		// random sets, mostly small, with a stretch of no idling
		random_words = 0;
		run = 0;
		while (random_words < 50) begin
			calm = (run >= 1 && run < 4);
			n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
			vs = {};
			for (i = 0; i < n; i++) vs.push_back(pick_value());
			send_set(vs);
			random_words += n;
			run++;
		end
		calm = 0;
		in_valid <= 0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d data sets, %0d result words checked, incl. buffer and table",
			runs_seen, words_seen);
		$display("overflow, duplicate triplets, short sets and 16-bit extremes.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#100ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
